### rtl/core/conv2d_valid_q16_16_assert.svh
// ----------------------------------------------------------------------------
// conv2d_valid_q16_16 assertion macros
// Shorthand for the clocked, reset-qualified properties of the convolution
// core. The including module provides clk and rst.
// ----------------------------------------------------------------------------
`ifndef CONV2D_VALID_Q16_16_ASSERT_SVH
`define CONV2D_VALID_Q16_16_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define CV2D_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CV2D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/cv2d_pkg.sv
// ----------------------------------------------------------------------------
// cv2d_pkg
// Shared types and constants of the Q16.16 valid-padding convolution core.
// ----------------------------------------------------------------------------
package cv2d_pkg;

  // Configuration port widths
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS = CFG_IDX_W'(3);

  // Request types
  localparam logic REQ_KERNEL = 1'b0;
  localparam logic REQ_PIXEL  = 1'b1;

  // Rounding constant: half of one result LSB, in the Q32.32 accumulator scale
  localparam logic [63:0] ROUND_HALF = 64'd32768;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND,
    ST_DONE
  } cv2d_state_t;

endpackage

### rtl/core/cv2d_if.sv
// ----------------------------------------------------------------------------
// cv2d channel interfaces
// Valid/ready channels for requests, results and configuration writes.
// ----------------------------------------------------------------------------
interface cv2d_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] data_word;

  modport source (output valid, output req_type, output data_word, input ready);
  modport sink   (input valid, input req_type, input data_word, output ready);
endinterface

interface cv2d_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result;
  logic               overflow;
  logic               frame_last;

  modport source (output valid, output result, output overflow, output frame_last,
                  input ready);
  modport sink   (input valid, input result, input overflow, input frame_last,
                  output ready);
endinterface

interface cv2d_cfg_if;
  import cv2d_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

### rtl/core/conv2d_valid_q16_16.sv
// ----------------------------------------------------------------------------
// conv2d_valid_q16_16
// Valid-padding 2D convolution on Q16.16 samples with one shared MAC.
// ----------------------------------------------------------------------------
// Kernel words, and pixels that complete no window, are taken one per cycle
// while the sequencer is idle. A pixel that completes a kernel window starts
// a walk of its kernel_rows*kernel_cols taps: the single multiply-accumulate
// unit walks the taps one per cycle, followed by the read/multiply drain, a
// rounding step and the load of the result register. The request
// channel is not ready until the sequencer is idle again. The result register
// lets the next request be taken while a result still waits on the output.
// Configuration writes are taken in any cycle; a write to one of the four
// configuration registers returns the kernel load index and pixel position to zero.
module conv2d_valid_q16_16 #(
  parameter int MAX_COLS   = 1024,
  parameter int MAX_KERNEL = 5
) (
  input  logic         clk,
  input  logic         rst,
  cv2d_in_if.sink      req,
  cv2d_out_if.source   rsp,
  cv2d_cfg_if.sink     cfg
);
  import cv2d_pkg::*;

  localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SW     = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int KDEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int KIW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;

  // Configuration registers
  logic [15:0] image_rows;
  logic [10:0] image_cols;
  logic [2:0]  kernel_rows;
  logic [2:0]  kernel_cols;

  // Load and stream position
  logic [KIW-1:0] kidx;
  logic [CW-1:0]  pixel_col;
  logic [15:0]    pixel_row;
  logic [SW-1:0]  row_slot;

  // Storage
  logic [31:0] kern_mem [KDEPTH];
  logic [31:0] line_mem [MAX_KERNEL][MAX_COLS];

  // Window walk
  cv2d_state_t     state, state_next;
  logic [2:0]      tap_i;
  logic [2:0]      tap_j;
  logic [KIW-1:0]  kaddr;
  logic [SW-1:0]   rd_slot;
  logic [CW-1:0]   win_left;
  logic [CW-1:0]   rd_col;
  logic            last_q;
  logic            last_tap;

  // MAC pipeline
  logic signed [31:0] kd;
  logic signed [31:0] ld;
  logic signed [63:0] prod;
  logic [63:0]        acc;
  logic               rd_v;
  logic               mul_v;

  // Result register
  logic               out_valid;
  logic signed [31:0] out_result;
  logic               out_ovf;
  logic               out_last;

  // Handshake and position decode
  logic           cfg_acc;
  logic           kw_acc;
  logic           px_acc;
  logic           out_free;
  logic [5:0]     taps;
  logic [KIW-1:0] kidx_eff;
  logic [KIW-1:0] kidx_inc;
  logic [CW-1:0]  col_eff;
  logic [15:0]    row_eff;
  logic [SW-1:0]  slot_eff;
  logic [SW-1:0]  slot_inc;
  logic [SW-1:0]  top_slot;
  logic [2:0]     krow_m1;
  logic [CW-1:0]  left;
  logic           win;
  logic           last_pix;
  logic           col_wrap;
  logic           row_wrap;

  function automatic logic [15:0] clamp_count(input logic [15:0] v, input int unsigned hi);
    if (v == 16'd0) begin
      return 16'd1;
    end
    if (32'(v) > hi) begin
      return 16'(hi);
    end
    return v;
  endfunction

  assign cfg.ready  = 1'b1;
  assign req.ready  = (state == ST_IDLE);
  assign cfg_acc    = cfg.valid && cfg.ready;
  assign kw_acc     = req.valid && req.ready && (req.req_type == REQ_KERNEL);
  assign px_acc     = req.valid && req.ready && (req.req_type == REQ_PIXEL);
  assign out_free   = !out_valid || rsp.ready;

  assign rsp.valid      = out_valid;
  assign rsp.result     = out_result;
  assign rsp.overflow   = out_ovf;
  assign rsp.frame_last = out_last;

  // Decode the kernel load index and the current pixel position
  always_comb begin
    taps     = {3'b000, kernel_rows} * {3'b000, kernel_cols};
    kidx_eff = (32'(kidx) >= 32'(taps)) ? '0 : kidx;
    kidx_inc = (32'(kidx_eff) + 1 >= 32'(taps)) ? '0 : KIW'(32'(kidx_eff) + 1);

    col_eff  = (32'(pixel_col) >= 32'(image_cols)) ? '0 : pixel_col;
    row_eff  = (pixel_row >= image_rows) ? 16'd0 : pixel_row;
    slot_eff = (pixel_row >= image_rows) ? '0 : row_slot;
    slot_inc = (32'(slot_eff) + 1 >= MAX_KERNEL) ? '0 : SW'(32'(slot_eff) + 1);

    krow_m1  = kernel_rows - 3'd1;
    top_slot = (32'(slot_eff) >= 32'(krow_m1)) ?
               SW'(32'(slot_eff) - 32'(krow_m1)) :
               SW'(32'(slot_eff) + MAX_KERNEL - 32'(krow_m1));
    left     = CW'(12'(col_eff) + 12'd1 - 12'(kernel_cols));

    win      = (16'(kernel_rows) <= image_rows) && (11'(kernel_cols) <= image_cols) &&
               (17'(row_eff) + 17'd1 >= 17'(kernel_rows)) &&
               (12'(col_eff) + 12'd1 >= 12'(kernel_cols));
    last_pix = (17'(row_eff) + 17'd1 == 17'(image_rows)) &&
               (12'(col_eff) + 12'd1 == 12'(image_cols));
    col_wrap = (12'(col_eff) + 12'd1 >= 12'(image_cols));
    row_wrap = (17'(row_eff) + 17'd1 >= 17'(image_rows));

    last_tap = (tap_i == krow_m1) && (tap_j == kernel_cols - 3'd1);
    rd_col   = win_left + CW'(tap_j);
  end

  // Configuration registers, kernel load index and stream position
  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows  <= 16'd1;
      image_cols  <= 11'd1;
      kernel_rows <= 3'd1;
      kernel_cols <= 3'd1;
      kidx        <= '0;
      pixel_col   <= '0;
      pixel_row   <= 16'd0;
      row_slot    <= '0;
    end else if (cfg_acc) begin
      unique case (cfg.index)
        CFG_IMAGE_ROWS: begin
          image_rows <= clamp_count(cfg.wdata, 65535);
        end
        CFG_IMAGE_COLS: begin
          image_cols <= 11'(clamp_count({5'd0, cfg.wdata[10:0]}, MAX_COLS));
        end
        CFG_KERNEL_ROWS: begin
          kernel_rows <= 3'(clamp_count({13'd0, cfg.wdata[2:0]}, MAX_KERNEL));
        end
        CFG_KERNEL_COLS: begin
          kernel_cols <= 3'(clamp_count({13'd0, cfg.wdata[2:0]}, MAX_KERNEL));
        end
        default: begin
        end
      endcase
      if (cfg.index == CFG_IMAGE_ROWS || cfg.index == CFG_IMAGE_COLS ||
          cfg.index == CFG_KERNEL_ROWS || cfg.index == CFG_KERNEL_COLS) begin
        kidx      <= '0;
        pixel_col <= '0;
        pixel_row <= 16'd0;
        row_slot  <= '0;
      end
    end else if (kw_acc) begin
      kidx <= kidx_inc;
    end else if (px_acc) begin
      if (col_wrap) begin
        pixel_col <= '0;
        pixel_row <= row_wrap ? 16'd0 : row_eff + 16'd1;
        row_slot  <= row_wrap ? '0 : slot_inc;
      end else begin
        pixel_col <= col_eff + CW'(1);
        pixel_row <= row_eff;
        row_slot  <= slot_eff;
      end
    end
  end

  // Kernel store: write on load, read one tap per cycle
  always_ff @(posedge clk) begin
    if (kw_acc) begin
      kern_mem[kidx_eff] <= req.data_word;
    end
    kd <= kern_mem[kaddr];
  end

  // Line store: write each pixel, read one window tap per cycle
  always_ff @(posedge clk) begin
    if (px_acc) begin
      line_mem[slot_eff][col_eff] <= req.data_word;
    end
    ld <= line_mem[rd_slot][rd_col];
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (px_acc && win) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_tap) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v && !mul_v) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Walk the taps: arm on a window pixel, advance one tap per cycle
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && px_acc && win) begin
      tap_i    <= 3'd0;
      tap_j    <= 3'd0;
      kaddr    <= '0;
      rd_slot  <= top_slot;
      win_left <= left;
      last_q   <= last_pix;
    end else if (state == ST_RUN) begin
      kaddr <= kaddr + KIW'(1);
      if (tap_j == kernel_cols - 3'd1) begin
        tap_j   <= 3'd0;
        tap_i   <= tap_i + 3'd1;
        rd_slot <= (32'(rd_slot) + 1 >= MAX_KERNEL) ? '0 : SW'(32'(rd_slot) + 1);
      end else begin
        tap_j <= tap_j + 3'd1;
      end
    end
  end

  // Track reads and products in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      mul_v <= 1'b0;
    end else begin
      rd_v  <= (state == ST_RUN);
      mul_v <= rd_v;
    end
  end

  // Multiply, accumulate modulo 2^64, then add one half for rounding
  always_ff @(posedge clk) begin
    prod <= kd * ld;
    if (state == ST_IDLE && px_acc && win) begin
      acc <= 64'd0;
    end else if (mul_v) begin
      acc <= acc + prod;
    end else if (state == ST_ROUND) begin
      acc <= acc + ROUND_HALF;
    end
  end

  // Result register: load the shifted sum, hold until transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_result <= acc[47:16];
      out_ovf    <= !((&acc[63:47]) || !(|acc[63:47]));
      out_last   <= last_q;
    end
  end

  `include "conv2d_valid_q16_16_assert.svh"

  `CV2D_ASSERT_SAME(a_kidx_in_range, 1'b1, 32'(kidx) < 32'(taps), "kernel index beyond taps")
  `CV2D_ASSERT_NEXT(a_window_starts, px_acc && win, state == ST_RUN && tap_i == 3'd0, "walk not armed")
  `CV2D_ASSERT_SAME(a_idle_pipe_empty, state == ST_IDLE, !rd_v && !mul_v, "MAC busy while idle")
  `CV2D_ASSERT_NEXT(a_done_waits, state == ST_DONE && !out_free, state == ST_DONE, "result dropped")

endmodule
